FILE: sv/sm4_pkg.sv
// Package: SM4 constants, command codes, S-box table and round function.
package sm4_pkg;

   localparam int ROUNDS_DEFAULT = 32;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_ENCRYPT = 2'd1,
      CMD_DECRYPT = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // One round: x0 ^ L(S(x1 ^ x2 ^ x3 ^ rk)).
   function automatic logic [31:0] round_f(input logic [31:0] x0, input logic [31:0] x1,
                                           input logic [31:0] x2, input logic [31:0] x3,
                                           input logic [31:0] rk);
      logic [31:0] t;
      logic [31:0] s;
      t = x1 ^ x2 ^ x3 ^ rk;
      s = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
      round_f = x0 ^ s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
   endfunction

endpackage

FILE: sv/sm4_block_cipher_core.sv
// SM4 block cipher core, top level.
//
// SM4 engine with round keys loaded from outside. A request with command load
// writes key_word into slot key_index and gives no response; encrypt and
// decrypt requests carry one 128-bit block and give one response. The datapath
// is an input register followed by ROUNDS register stages, one round per stage,
// so a new block may enter in every cycle while the pipe advances, and the
// response leaves from the last stage; a stalled response freezes the
// whole pipe. Each round stage reads its own key register (slot i for encrypt,
// ROUNDS-1-i for decrypt). A load request is held off while any block still has
// rounds to run, so every block sees the keys that were in place when it was
// accepted; the hold lasts until the last such block reaches the output stage.
// Command 3 is dropped silently.
module sm4_block_cipher_core
   import sm4_pkg::*;
#(
   parameter int ROUNDS = ROUNDS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], key_index[6:2], key_word[38:7], block_high[102:39],
   // block_low[166:103], zero fill up to 167
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_high[63:0], result_low[127:64]
   output logic [127:0] rsp_tdata
);

   localparam int KW = $clog2(ROUNDS);

   logic [31:0]  key_ff [ROUNDS];
   logic [ROUNDS:0]  vld_ff;
   logic [ROUNDS:0]  dec_ff;
   logic [127:0] blk_ff [ROUNDS+1];
   logic         adv;
   logic         key_busy;
   logic         load_hold;
   cmd_type      cmd;
   logic [KW-1:0] kidx;

   assign cmd  = cmd_type'(req_tdata[1:0]);
   assign kidx = req_tdata[2 +: KW];

   // Pipe advances unless the output stage holds an untaken response.
   assign adv        = !vld_ff[ROUNDS] || rsp_tready;
   // Hold a load while some block still has rounds left to read keys.
   assign key_busy   = |vld_ff[ROUNDS-1:0];
   assign load_hold  = (cmd == CMD_LOAD) && key_busy;
   assign req_tready = adv && !load_hold;
   assign rsp_tvalid = vld_ff[ROUNDS];
   // Output words X33 X32 in the high half, X35 X34 in the low half.
   assign rsp_tdata  = {blk_ff[ROUNDS][95:64], blk_ff[ROUNDS][127:96],
                        blk_ff[ROUNDS][31:0], blk_ff[ROUNDS][63:32]};

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && cmd == CMD_LOAD) begin
         key_ff[kidx] <= req_tdata[38:7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ROUNDS-1:0],
                    req_tvalid && (cmd == CMD_ENCRYPT || cmd == CMD_DECRYPT)};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         blk_ff[0] <= {req_tdata[102:39], req_tdata[166:103]};
         dec_ff[0] <= (cmd == CMD_DECRYPT);
         for (int i = 0; i < ROUNDS; i++) begin
            blk_ff[i+1] <= {blk_ff[i][95:0],
                            round_f(blk_ff[i][127:96], blk_ff[i][95:64],
                                    blk_ff[i][63:32], blk_ff[i][31:0],
                                    dec_ff[i] ? key_ff[ROUNDS-1-i] : key_ff[i])};
            dec_ff[i+1] <= dec_ff[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !load_hold |-> req_tready)
      else $error("pipe stalled with empty output");
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && cmd == CMD_LOAD |=> !vld_ff[0])
      else $error("load request entered datapath");
`endif

endmodule
